// ----- sv/stdc_pkg.sv -----
// Package with the shared types and constants of the system tick down counter.
package stdc_pkg;

   localparam int DATA_WIDTH = 24;
   localparam int FLAG_BIT = 16;
   localparam int ENABLE_BIT = 0;
   localparam int IRQ_ENABLE_BIT = 1;
   localparam int FAST_CLOCK_BIT = 2;

   typedef enum logic [1:0] {
      CMD_TICK  = 2'd0,
      CMD_READ  = 2'd1,
      CMD_WRITE = 2'd2
   } command_type;

   typedef enum logic [1:0] {
      SEL_CONTROL = 2'd0,
      SEL_RELOAD  = 2'd1,
      SEL_CURRENT = 2'd2
   } reg_select_type;

   typedef struct packed {
      logic [1:0]            command;
      logic [1:0]            reg_select;
      logic [DATA_WIDTH-1:0] write_data;
   } request_type;

   typedef struct packed {
      logic [DATA_WIDTH-1:0] read_data;
      logic                  irq_pulse;
      logic                  running;
   } response_type;

endpackage

// ----- sv/stdc_in_stage.sv -----
// Input register stage that holds one request transaction for the counter core.
module stdc_in_stage
   import stdc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  request_type in_data,
   output logic        out_valid,
   input  logic        out_ready,
   output request_type out_data
);

   logic        valid_ff;
   logic        valid_in;
   request_type data_ff;

   // The stage refills in the same cycle that the core drains it.
   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_valid || (valid_ff && !out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= in_data;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ----- sv/stdc_core.sv -----
// Counter core: timer state, register access and the registered response.
module stdc_core
   import stdc_pkg::*;
#(
   parameter int COUNTER_WIDTH = 24,
   parameter int SLOW_DIVIDE = 8
)
(
   input  logic         clock,
   input  logic         reset,
   input  logic         single_shot,
   input  logic         in_valid,
   output logic         in_ready,
   input  request_type  in_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output response_type rsp_data
);

   localparam int PRESCALE_WIDTH = $clog2(SLOW_DIVIDE);
   localparam int WIDE_WIDTH = COUNTER_WIDTH + DATA_WIDTH;
   localparam logic [PRESCALE_WIDTH-1:0] PRESCALE_LAST = PRESCALE_WIDTH'(SLOW_DIVIDE - 1);

   logic                      enable_ff, enable_in;
   logic                      irq_enable_ff, irq_enable_in;
   logic                      fast_clock_ff, fast_clock_in;
   logic                      count_flag_ff, count_flag_in;
   logic [COUNTER_WIDTH-1:0]  reload_ff, reload_in;
   logic [COUNTER_WIDTH-1:0]  count_ff, count_in;
   logic [PRESCALE_WIDTH-1:0] prescale_ff, prescale_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   response_type              rsp_ff, rsp_in;

   logic                      fire;
   logic                      count_step;
   logic [COUNTER_WIDTH-1:0]  count_dec;
   logic [WIDE_WIDTH-1:0]     data_wide;
   logic [WIDE_WIDTH-1:0]     reload_wide;
   logic [WIDE_WIDTH-1:0]     count_wide;
   logic [DATA_WIDTH-1:0]     read_data;
   logic                      pulse;

   assign in_ready = !rsp_valid_ff || rsp_ready;
   assign fire     = in_valid && in_ready;

   // Zero-extend through a wide word so any counter width lines up with the data bus.
   assign data_wide   = {{COUNTER_WIDTH{1'b0}}, in_data.write_data};
   assign reload_wide = {{DATA_WIDTH{1'b0}}, reload_ff};
   assign count_wide  = {{DATA_WIDTH{1'b0}}, count_ff};
   assign count_dec   = count_ff - COUNTER_WIDTH'(1);
   assign count_step  = fast_clock_ff || (prescale_ff == PRESCALE_LAST);

   always_comb begin
      enable_in     = enable_ff;
      irq_enable_in = irq_enable_ff;
      fast_clock_in = fast_clock_ff;
      count_flag_in = count_flag_ff;
      reload_in     = reload_ff;
      count_in      = count_ff;
      prescale_in   = prescale_ff;
      read_data     = '0;
      pulse         = 1'b0;
      if (fire) begin
         unique case (in_data.command)
            CMD_TICK: begin
               if (enable_ff) begin
                  if (!fast_clock_ff) begin
                     prescale_in = (prescale_ff == PRESCALE_LAST) ? '0
                                 : prescale_ff + PRESCALE_WIDTH'(1);
                  end
                  if (count_step) begin
                     if (count_ff == '0) begin
                        count_in = reload_ff;
                     end else begin
                        count_in = count_dec;
                        if (count_dec == '0) begin
                           count_flag_in = 1'b1;
                           pulse         = irq_enable_ff;
                           if (single_shot) begin
                              enable_in     = 1'b0;
                              irq_enable_in = 1'b0;
                              reload_in     = '0;
                           end
                        end
                     end
                  end
               end
            end
            CMD_READ: begin
               unique case (in_data.reg_select)
                  SEL_CONTROL: begin
                     read_data[ENABLE_BIT]     = enable_ff;
                     read_data[IRQ_ENABLE_BIT] = irq_enable_ff;
                     read_data[FAST_CLOCK_BIT] = fast_clock_ff;
                     read_data[FLAG_BIT]       = count_flag_ff;
                     count_flag_in             = 1'b0;
                  end
                  SEL_RELOAD:  read_data = reload_wide[DATA_WIDTH-1:0];
                  SEL_CURRENT: read_data = count_wide[DATA_WIDTH-1:0];
                  default: ;
               endcase
            end
            CMD_WRITE: begin
               unique case (in_data.reg_select)
                  SEL_CONTROL: begin
                     enable_in     = in_data.write_data[ENABLE_BIT];
                     irq_enable_in = in_data.write_data[IRQ_ENABLE_BIT];
                     fast_clock_in = in_data.write_data[FAST_CLOCK_BIT];
                  end
                  SEL_RELOAD: reload_in = data_wide[COUNTER_WIDTH-1:0];
                  SEL_CURRENT: begin
                     count_in      = '0;
                     count_flag_in = 1'b0;
                  end
                  default: ;
               endcase
            end
            default: ;
         endcase
      end
   end

   assign rsp_valid_in      = fire || (rsp_valid_ff && !rsp_ready);
   assign rsp_in.read_data  = read_data;
   assign rsp_in.irq_pulse  = pulse;
   assign rsp_in.running    = enable_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff     <= 1'b0;
         irq_enable_ff <= 1'b0;
         fast_clock_ff <= 1'b0;
         count_flag_ff <= 1'b0;
         reload_ff     <= '0;
         count_ff      <= '0;
         prescale_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         enable_ff     <= enable_in;
         irq_enable_ff <= irq_enable_in;
         fast_clock_ff <= fast_clock_in;
         count_flag_ff <= count_flag_in;
         reload_ff     <= reload_in;
         count_ff      <= count_in;
         prescale_ff   <= prescale_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // An interrupt pulse always comes with the flag set in the same update.
   assert property (@(posedge clock) disable iff (reset)
      ($past(fire) && rsp_valid_ff && rsp_ff.irq_pulse) |-> count_flag_ff)
      else $error("irq pulse without count flag");

   // Only ticks raise a pulse, and ticks return no read data.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.irq_pulse) |-> (rsp_ff.read_data == '0))
      else $error("irq pulse with read data");

   // A single-shot expiry leaves the timer stopped and cleared.
   assert property (@(posedge clock) disable iff (reset)
      ($past(fire) && rsp_valid_ff && rsp_ff.irq_pulse && $past(single_shot))
      |-> (!enable_ff && !irq_enable_ff && reload_ff == '0 && count_ff == '0))
      else $error("single-shot expiry did not stop the timer");

   // The prescaler never passes the last slot of the divider.
   assert property (@(posedge clock) disable iff (reset)
      prescale_ff <= PRESCALE_LAST)
      else $error("prescaler out of range");

endmodule

// ----- sv/system_tick_down_counter.sv -----
// Top level of the system tick down counter: control register, input stage and core.
//
//   channel  direction  ports                                   transaction
//   req      in         command, reg_select, write_data         tick, read or write
//   rsp      out        read_data, irq_pulse, running           one per request
//   csr      in         single_shot                             mode write
//
// One request per cycle is accepted while the response is not stalled; each response passes
// through the input register and then the result register.
// The timer update is a single decrement and compare on the counter.
// Reset is synchronous and clears every control bit, the counter, reload and prescaler.
// A stalled response holds the result register and stops the core; req_ready drops once
// the input register is full while the core is stalled.
module system_tick_down_counter
   import stdc_pkg::*;
#(
   parameter int COUNTER_WIDTH = 24,
   parameter int SLOW_DIVIDE = 8
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_command,
   input  logic [1:0]            req_reg_select,
   input  logic [DATA_WIDTH-1:0] req_write_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [DATA_WIDTH-1:0] rsp_read_data,
   output logic                  rsp_irq_pulse,
   output logic                  rsp_running,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic                  csr_single_shot
);

   logic         single_shot_ff;
   request_type  req_data;
   request_type  stage_data;
   logic         stage_valid;
   logic         stage_ready;
   response_type rsp_data;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         single_shot_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         single_shot_ff <= csr_single_shot;
      end
   end

   assign req_data.command    = req_command;
   assign req_data.reg_select = req_reg_select;
   assign req_data.write_data = req_write_data;

   stdc_in_stage u_in_stage (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (req_data),
      .out_valid (stage_valid),
      .out_ready (stage_ready),
      .out_data  (stage_data)
   );

   stdc_core #(
      .COUNTER_WIDTH (COUNTER_WIDTH),
      .SLOW_DIVIDE   (SLOW_DIVIDE)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .single_shot (single_shot_ff),
      .in_valid    (stage_valid),
      .in_ready    (stage_ready),
      .in_data     (stage_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

   assign rsp_read_data = rsp_data.read_data;
   assign rsp_irq_pulse = rsp_data.irq_pulse;
   assign rsp_running   = rsp_data.running;

endmodule
